// ===== rtl/simon_block_cipher_defines.svh =====
// Assertion macros shared by the Simon cipher RTL.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef SIMON_BLOCK_CIPHER_DEFINES_SVH
`define SIMON_BLOCK_CIPHER_DEFINES_SVH

// Property checked on every clock edge outside reset
`define SBC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition in the cycle after a trigger
`define SBC_ASSERT_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) else $error(msg);

`endif

// ===== rtl/sbc_pkg.sv =====
// Package for the Simon 32/64 cipher: word types, constants, round and key functions.
// No dependencies; imported by every module of the block.
package sbc_pkg;

	localparam int WORD_BITS   = 16;
	localparam int ROUND_COUNT = 32;
	localparam int KEY_WORDS   = 4;
	localparam int RND_BITS    = $clog2(ROUND_COUNT);

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [RND_BITS-1:0]  rnd_t;

	// Operation codes
	localparam logic OP_ENCRYPT = 1'b0;
	localparam logic OP_DECRYPT = 1'b1;

	// First 32 bits of the z0 sequence, bit j used for key word j+4
	localparam logic [0:ROUND_COUNT-1] Z0_SEQ = 32'b11111010001001010110000111001101;

	// Complemented constant folded in: ~k ^ 3 == k ^ 16'hfffc
	localparam word_t KEY_CONST = 16'hfffc;

	// Round-key write port from the schedule generator
	typedef struct packed {
		logic  en;
		rnd_t  addr;
		word_t data;
	} key_wr_t;

	// Sequencer commands to the round datapath
	typedef struct packed {
		logic load;
		logic step;
	} rnd_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROUND,
		ST_DONE
	} state_t;

	// Feistel function: (x <<< 1 & x <<< 8) ^ x <<< 2
	function automatic word_t round_fn(input word_t x);
		word_t r1, r2, r8;
		r1 = {x[WORD_BITS-2:0], x[WORD_BITS-1]};
		r2 = {x[WORD_BITS-3:0], x[WORD_BITS-1:WORD_BITS-2]};
		r8 = {x[WORD_BITS-9:0], x[WORD_BITS-1:WORD_BITS-8]};
		return (r1 & r8) ^ r2;
	endfunction

	// Next key word from k[i-4], k[i-3], k[i-1] and z bit
	function automatic word_t key_next(input word_t k0, input word_t k1, input word_t k3,
			input logic z);
		word_t t;
		t = {k3[2:0], k3[WORD_BITS-1:3]} ^ k1;
		t = t ^ {t[0], t[WORD_BITS-1:1]};
		return k0 ^ t ^ KEY_CONST ^ {{(WORD_BITS-1){1'b0}}, z};
	endfunction

endpackage

// ===== rtl/simon_block_cipher.sv =====
// Simon 32/64 block cipher. An item is accepted, then runs 32 Feistel rounds on the one
// shared round unit, one round a cycle with the round key read from the registered key
// store in the cycle before; the result is offered on the cycle after the last round. A
// new item is accepted only once the result has been taken. The store is filled by the
// key schedule, one round key a cycle, after reset and after every write of cipher_key;
// no item is accepted while that fill runs.
`include "simon_block_cipher_defines.svh"

module simon_block_cipher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cipher_key_we,
	input  logic [63:0] cipher_key,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [31:0] data_block,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] result_block
);
	import sbc_pkg::*;

	key_wr_t  ks_wr;
	logic     ks_busy;
	rnd_t     key_addr;
	word_t    round_key;
	logic     rnd_last;
	rnd_ctl_t ctl;
	state_t   state_q, state_d;

	sbc_key_sched u_key_sched (
		.clk    (clk),
		.arst_n (arst_n),
		.key_we (cipher_key_we),
		.key    (cipher_key),
		.wr     (ks_wr),
		.busy   (ks_busy)
	);

	sbc_key_ram u_key_ram (
		.clk     (clk),
		.wr      (ks_wr),
		.rd_addr (key_addr),
		.rd_data (round_key)
	);

	sbc_round u_round (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.operation    (operation),
		.data_block   (data_block),
		.round_key    (round_key),
		.key_addr     (key_addr),
		.last         (rnd_last),
		.result_block (result_block)
	);

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// Next state and commands
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		ctl       = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = !ks_busy && !cipher_key_we;
				if (in_valid && in_ready) begin
					ctl.load = 1'b1;
					state_d  = ST_ROUND;
				end
			end
			ST_ROUND: begin
				ctl.step = 1'b1;
				if (rnd_last) state_d = ST_DONE;
			end
			ST_DONE: begin
				out_valid = 1'b1;
				if (out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	`SBC_ASSERT(a_no_accept_in_keygen, !(in_ready && ks_busy), "item accepted during key expansion")
	`SBC_ASSERT_NEXT(a_key_write_restarts, cipher_key_we, ks_busy, "key write did not start schedule")
	`SBC_ASSERT_NEXT(a_last_round_done, (state_q == ST_ROUND) && rnd_last, out_valid, "no result after last round")
	`SBC_ASSERT_NEXT(a_one_item_at_once, in_valid && in_ready, !in_ready && !out_valid, "second item taken while busy")

endmodule

// ===== rtl/sbc_key_sched.sv =====
// Key schedule generator: expands the 64-bit key into 32 round keys, one a cycle.
// Uses sbc_pkg; drives the write port of sbc_key_ram.
module sbc_key_sched (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   key_we,
	input  logic [sbc_pkg::KEY_WORDS*sbc_pkg::WORD_BITS-1:0] key,
	output sbc_pkg::key_wr_t                       wr,
	output logic                                   busy
);
	import sbc_pkg::*;

	word_t win_q [KEY_WORDS];
	rnd_t  cnt_q;
	logic  busy_q;

	// Sliding window of four key words; oldest word is written each cycle while busy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
			for (int i = 0; i < KEY_WORDS; i++) win_q[i] <= '0;
		end else if (key_we) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
			for (int i = 0; i < KEY_WORDS; i++) win_q[i] <= key[i*WORD_BITS +: WORD_BITS];
		end else if (busy_q) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2] <= win_q[3];
			win_q[3] <= key_next(win_q[0], win_q[1], win_q[3], Z0_SEQ[cnt_q]);
			cnt_q    <= cnt_q + rnd_t'(1);
			if (cnt_q == rnd_t'(ROUND_COUNT - 1)) busy_q <= 1'b0;
		end
	end

	assign wr.en   = busy_q;
	assign wr.addr = cnt_q;
	assign wr.data = win_q[0];
	assign busy    = busy_q;

endmodule

// ===== rtl/sbc_key_ram.sv =====
// Round-key store: 32 x 16 memory, one write port, one registered read port.
// Uses sbc_pkg; written by sbc_key_sched, read by sbc_round.
module sbc_key_ram (
	input  logic             clk,
	input  sbc_pkg::key_wr_t wr,
	input  sbc_pkg::rnd_t    rd_addr,
	output sbc_pkg::word_t   rd_data
);
	import sbc_pkg::*;

	word_t mem [ROUND_COUNT];
	word_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) mem[wr.addr] <= wr.data;
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/sbc_round.sv =====
// Shared round unit: one Feistel round a cycle while stepped, plus the round counter.
// Uses sbc_pkg; takes round keys from sbc_key_ram, commands from the top level.
module sbc_round (
	input  logic              clk,
	input  logic              arst_n,
	input  sbc_pkg::rnd_ctl_t ctl,
	input  logic              operation,
	input  logic [2*sbc_pkg::WORD_BITS-1:0] data_block,
	input  sbc_pkg::word_t    round_key,
	output sbc_pkg::rnd_t     key_addr,
	output logic              last,
	output logic [2*sbc_pkg::WORD_BITS-1:0] result_block
);
	import sbc_pkg::*;

	// a is the word fed through f, b the other; decrypt swaps x and y
	word_t a_q, b_q;
	rnd_t  rnd_q;
	logic  dec_q;
	rnd_t  rnd_nxt;
	word_t in_x, in_y;

	assign in_x    = data_block[2*WORD_BITS-1:WORD_BITS];
	assign in_y    = data_block[WORD_BITS-1:0];
	assign rnd_nxt = rnd_q + rnd_t'(1);

	// Counter and mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_q <= '0;
			dec_q <= OP_ENCRYPT;
		end else if (ctl.load) begin
			rnd_q <= '0;
			dec_q <= operation;
		end else if (ctl.step) begin
			rnd_q <= rnd_nxt;
		end
	end

	// Data words
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			a_q <= (operation == OP_DECRYPT) ? in_y : in_x;
			b_q <= (operation == OP_DECRYPT) ? in_x : in_y;
		end else if (ctl.step) begin
			a_q <= b_q ^ round_fn(a_q) ^ round_key;
			b_q <= a_q;
		end
	end

	// Key read one round ahead; decrypt walks the store backwards
	always_comb begin
		if (ctl.load) key_addr = (operation == OP_DECRYPT) ? rnd_t'(ROUND_COUNT - 1) : '0;
		else key_addr = (dec_q == OP_DECRYPT) ? ~rnd_nxt : rnd_nxt;
	end

	assign last         = (rnd_q == rnd_t'(ROUND_COUNT - 1));
	assign result_block = (dec_q == OP_DECRYPT) ? {b_q, a_q} : {a_q, b_q};

endmodule
